/* rtl/core/fha_pkg.sv */
// ----------------------------------------------------------------------------
// fha_pkg
// shared widths, sizes and helpers of the frame history averager
// ----------------------------------------------------------------------------
package fha_pkg;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int CH_W      = 2;
  localparam int BIN_W     = 10;
  localparam int LEN_W     = 7;

  // ring of past frames
  localparam int MAX_AVERAGE = 64;
  localparam int SLOT_W      = 6;
  localparam int DEPTH_W     = 7;

  // history memory: one entry per slot, channel and bin
  localparam int ADDR_W    = SLOT_W + CH_W + BIN_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // running sum over up to MAX_AVERAGE samples, and the divider built on it
  localparam int SUM_W     = SAMPLE_W + SLOT_W;
  localparam int DIVCNT_W  = 5;

  typedef logic [DEPTH_W-1:0] depth_t;

  // setting clamped to 1..MAX_AVERAGE
  function automatic depth_t eff_setting(input logic [LEN_W-1:0] len);
    depth_t s;
    s = depth_t'(len);
    if (s == depth_t'(0)) begin
      s = depth_t'(1);
    end else if (s > depth_t'(MAX_AVERAGE)) begin
      s = depth_t'(MAX_AVERAGE);
    end
    return s;
  endfunction

endpackage

/* rtl/core/frame_history_averager.sv */
// ----------------------------------------------------------------------------
// frame_history_averager
// bin-by-bin boxcar average over a ring of past frames per channel
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    sample_value, channel_index,
//                                             bin_index, frame_end
//  out_     output     out_valid / out_stall  average_value, frame_done
//  cfg_     input      cfg_wr_en              cfg_wr_data (average_length)
//
//  one transaction at a time: from input accept to result load the block
//  does one history memory read per stored frame, then a 22-step restoring
//  divider; the next input can be taken in the cycle after the load
//  the sample is written at the accept edge, reads follow in later cycles
//  the result waits in the output register; a new input is taken meanwhile
//  reset (synchronous, rst_n low) clears control state, memory is not cleared
// ----------------------------------------------------------------------------
module frame_history_averager (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [fha_pkg::LEN_W-1:0]         cfg_wr_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fha_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [fha_pkg::CH_W-1:0]          in_channel_index,
  input  logic [fha_pkg::BIN_W-1:0]         in_bin_index,
  input  logic                              in_frame_end,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fha_pkg::SAMPLE_W-1:0] out_average_value,
  output logic                              out_frame_done
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int SW = fha_pkg::SUM_W;

  logic [2:0]                         state_r;
  logic [fha_pkg::LEN_W-1:0]          avg_len_r;
  fha_pkg::depth_t                    depth_r;
  logic [fha_pkg::SLOT_W-1:0]         slot_r;
  logic                               start_r;

  logic [fha_pkg::CH_W-1:0]           ch_r;
  logic [fha_pkg::BIN_W-1:0]          bin_r;
  logic                               last_r;

  fha_pkg::depth_t                    rd_cnt_r;
  logic                               rd_vld_r;
  logic [fha_pkg::SAMPLE_W-1:0]       rd_data_r;
  logic signed [SW-1:0]               sum_r;

  logic [SW-1:0]                      dq_r;
  logic [fha_pkg::DEPTH_W-1:0]        rem_r;
  logic                               neg_r;
  logic [fha_pkg::DIVCNT_W-1:0]       div_cnt_r;

  logic                               out_valid_r;
  logic [fha_pkg::SAMPLE_W-1:0]       out_avg_r;
  logic                               out_done_r;

  logic [fha_pkg::SAMPLE_W-1:0]       history_mem [0:fha_pkg::MEM_DEPTH-1];

  logic                               in_acc;
  logic                               out_acc;
  logic                               out_load;
  fha_pkg::depth_t                    set_w;
  fha_pkg::depth_t                    depth_nxt;
  logic [fha_pkg::SLOT_W-1:0]         slot_use;
  logic [fha_pkg::ADDR_W-1:0]         wr_addr;
  logic [fha_pkg::ADDR_W-1:0]         rd_addr;
  logic [fha_pkg::DEPTH_W:0]          rem_sh;
  logic                               rem_ge;
  logic [SW-1:0]                      sum_mag;
  logic [SW-1:0]                      quo_signed;

  // handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign out_valid         = out_valid_r;
  assign out_average_value = out_avg_r;
  assign out_frame_done    = out_done_r;

  // depth and write slot at frame start
  assign set_w = fha_pkg::eff_setting(avg_len_r);

  always_comb begin
    depth_nxt = depth_r;
    slot_use  = slot_r;
    if (start_r) begin
      if (depth_r > set_w) begin
        depth_nxt = set_w;
      end else if (depth_r < set_w) begin
        depth_nxt = depth_r + fha_pkg::depth_t'(1);
        slot_use  = fha_pkg::SLOT_W'(depth_nxt - fha_pkg::depth_t'(1));
      end
      if ({1'b0, slot_use} >= depth_nxt) begin
        slot_use = '0;
      end
    end
  end

  assign wr_addr = {slot_use, in_channel_index, in_bin_index};
  assign rd_addr = {rd_cnt_r[fha_pkg::SLOT_W-1:0], ch_r, bin_r};

  // divider step
  assign rem_sh = {rem_r, dq_r[SW-1]};
  assign rem_ge = (rem_sh >= {1'b0, depth_r});

  assign sum_mag    = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign quo_signed = neg_r ? (~dq_r + SW'(1)) : dq_r;

  // history memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      history_mem[wr_addr] <= in_sample_value;
    end
    rd_data_r <= history_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      avg_len_r   <= fha_pkg::LEN_W'(1);
      depth_r     <= '0;
      slot_r      <= '0;
      start_r     <= 1'b1;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        avg_len_r <= cfg_wr_data;
      end

      rd_vld_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            depth_r  <= depth_nxt;
            slot_r   <= in_frame_end ? slot_use + fha_pkg::SLOT_W'(1) : slot_use;
            start_r  <= in_frame_end;
            rd_cnt_r <= '0;
            state_r  <= ST_READ;
          end
        end
        ST_READ: begin
          rd_vld_r <= 1'b1;
          rd_cnt_r <= rd_cnt_r + fha_pkg::depth_t'(1);
          if (rd_cnt_r == depth_r - fha_pkg::depth_t'(1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_PREP;
        end
        ST_PREP: begin
          div_cnt_r <= fha_pkg::DIVCNT_W'(SW - 1);
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r - fha_pkg::DIVCNT_W'(1);
          if (div_cnt_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r   <= in_channel_index;
      bin_r  <= in_bin_index;
      last_r <= in_frame_end;
      sum_r  <= '0;
    end else if (rd_vld_r) begin
      sum_r <= sum_r + {{(SW - fha_pkg::SAMPLE_W){rd_data_r[fha_pkg::SAMPLE_W-1]}},
                        rd_data_r};
    end

    if (state_r == ST_PREP) begin
      dq_r  <= sum_mag;
      rem_r <= '0;
      neg_r <= sum_r[SW-1];
    end else if (state_r == ST_DIV) begin
      dq_r  <= {dq_r[SW-2:0], rem_ge};
      rem_r <= rem_ge ? fha_pkg::DEPTH_W'(rem_sh - {1'b0, depth_r})
                      : fha_pkg::DEPTH_W'(rem_sh);
    end

    if (out_load) begin
      out_avg_r  <= quo_signed[fha_pkg::SAMPLE_W-1:0];
      out_done_r <= last_r;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken while a transaction is in progress");

  a_slot_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
    !start_r |-> ({1'b0, slot_r} < depth_r))
    else $error("write slot outside depth in use");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (depth_r != '0) &&
                             (depth_r <= fha_pkg::depth_t'(fha_pkg::MAX_AVERAGE)))
    else $error("depth in use out of range during a transaction");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result shown before division finished");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_avg_r))
    else $error("waiting result overwritten");

endmodule
